// ===== rtl/core/timing_wheel_delay_queue_macros.svh =====
// Assertion helpers for the timing wheel delay queue.
`ifndef TIMING_WHEEL_DELAY_QUEUE_MACROS_SVH
`define TIMING_WHEEL_DELAY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/twdq_pkg.sv =====
package twdq_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int NODES_DEF      = 1024;
	localparam int ADDR_WIDTH_DEF = 32;
	localparam int LEN_WIDTH_DEF  = 16;

	// The unused request code decodes as a pop.
	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_ADVANCE = 2'd1,
		REQ_POP     = 2'd2
	} twdq_req_code_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_TOO_LONG = 3'd1,
		ST_FULL     = 3'd2,
		ST_ADVANCED = 3'd3,
		ST_POPPED   = 3'd4,
		ST_EMPTY    = 3'd5
	} twdq_status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  delay;
		logic [31:0] axon_address;
		logic [15:0] axon_length;
	} twdq_req_t;

	typedef struct packed {
		twdq_status_t status;
		logic [31:0]  out_address;
		logic [15:0]  out_length;
		logic         slot_drained;
	} twdq_rsp_t;

endpackage

// ===== rtl/core/timing_wheel_delay_queue.sv =====
// Channel  | Handshake    | Payload               | Direction
// ---------+--------------+-----------------------+----------
// request  | start / busy | req (twdq_req_t)      | in
// result   | done strobe  | result (twdq_rsp_t)   | out
//
// Each accepted request issues one read of the slot head memory and one of the node
// memory; the S_EXEC state then writes back and registers the result, which shows
// for one cycle with done high.
// After reset the block clears the slot head memory, one slot a cycle, and holds
// busy high until the last slot is cleared. The receiver cannot stall: results are not held.
module timing_wheel_delay_queue #(
	parameter int SLOTS      = twdq_pkg::SLOTS_DEF,
	parameter int NODES      = twdq_pkg::NODES_DEF,
	parameter int ADDR_WIDTH = twdq_pkg::ADDR_WIDTH_DEF,
	parameter int LEN_WIDTH  = twdq_pkg::LEN_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  twdq_pkg::twdq_req_t req,
	output logic                done,
	output twdq_pkg::twdq_rsp_t result
);

	import twdq_pkg::*;

	localparam int PW  = $clog2(SLOTS);
	localparam int NW  = $clog2(NODES);
	localparam int LW  = $clog2(NODES + 1);
	localparam int SW  = ((PW > 8) ? PW : 8) + 1;
	localparam int PLW = ADDR_WIDTH + LEN_WIDTH;
	localparam int NDW = LW + PLW;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t          state_q;
	logic            clr_q;
	logic [PW-1:0]   clr_cnt_q;
	logic [PW-1:0]   pos_q;
	logic [NW-1:0]   cur_head_q;
	logic [LW-1:0]   free_head_q;
	logic [LW-1:0]   hwm_q;
	twdq_req_t       req_s1;
	logic [PW-1:0]   slot_s1;
	logic            too_long_s1;
	logic            done_q;
	twdq_rsp_t       result_q;

	logic            accept;
	logic [SW-1:0]   slot_sum;
	logic [SW-1:0]   slot_wrap;
	logic [PW-1:0]   slot_acc;
	logic            too_long_acc;
	logic [PW-1:0]   pos_inc;

	logic            head_we;
	logic [PW-1:0]   head_waddr;
	logic [NW-1:0]   head_wdata;
	logic [PW-1:0]   head_raddr;
	logic [NW-1:0]   head_rdata;
	logic            head_we_x;
	logic [PW-1:0]   head_waddr_x;
	logic [NW-1:0]   head_wdata_x;

	logic            node_we;
	logic [NW-1:0]   node_waddr;
	logic [NDW-1:0]  node_wdata;
	logic [NW-1:0]   node_raddr;
	logic [NDW-1:0]  node_rdata;
	logic [LW-1:0]   next_rdata;

	logic [PLW-1:0]  pay_wdata;
	logic [PLW-1:0]  pay_rdata;

	logic            ins_fresh;
	logic [LW-1:0]   ins_link;
	logic            store_full;
	logic [PW-1:0]   pos_d;
	logic [NW-1:0]   cur_head_d;
	logic [LW-1:0]   free_head_d;
	logic [LW-1:0]   hwm_d;
	twdq_rsp_t       rsp_d;

	assign busy   = clr_q || (state_q == S_EXEC);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// Target slot: position plus delay, wrapped once.
	assign slot_sum     = SW'(pos_q) + SW'(req.delay);
	assign slot_wrap    = (slot_sum >= SW'(SLOTS)) ? slot_sum - SW'(SLOTS) : slot_sum;
	assign slot_acc     = slot_wrap[PW-1:0];
	assign too_long_acc = SW'(req.delay) >= SW'(SLOTS);
	assign pos_inc      = (pos_q == PW'(SLOTS - 1)) ? '0 : pos_q + 1'b1;

	assign head_raddr = (req.req_type == REQ_ADVANCE) ? pos_inc : slot_acc;
	assign node_raddr = (req.req_type == REQ_INSERT) ? free_head_q[NW-1:0] : cur_head_q;

	// Clearing pass owns the head write port after reset.
	assign head_we    = clr_q ? 1'b1 : head_we_x;
	assign head_waddr = clr_q ? clr_cnt_q : head_waddr_x;
	assign head_wdata = clr_q ? '0 : head_wdata_x;

	twdq_ram #(.DEPTH(SLOTS), .WIDTH(NW)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (accept),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	// Node word: link above payload.
	twdq_ram #(.DEPTH(NODES), .WIDTH(NDW)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (accept),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	assign next_rdata = node_rdata[PLW +: LW];
	assign pay_rdata  = node_rdata[PLW-1:0];

	// Nodes at the high-water mark were never linked: their link reads as null.
	assign ins_fresh  = (free_head_q == hwm_q);
	assign ins_link   = ins_fresh ? '0 : next_rdata;
	assign store_full = (free_head_q >= LW'(NODES));
	assign pay_wdata  = {ADDR_WIDTH'(req_s1.axon_address), LEN_WIDTH'(req_s1.axon_length)};

	always_comb begin
		head_we_x    = 1'b0;
		head_waddr_x = pos_q;
		head_wdata_x = '0;
		node_we      = 1'b0;
		node_waddr   = cur_head_q;
		node_wdata   = {free_head_q, pay_rdata};
		pos_d        = pos_q;
		cur_head_d   = cur_head_q;
		free_head_d  = free_head_q;
		hwm_d        = hwm_q;
		rsp_d        = '0;
		rsp_d.status = ST_ADVANCED;

		if (state_q == S_EXEC) begin
			case (req_s1.req_type)
				REQ_INSERT: begin
					if (too_long_s1) begin
						rsp_d.status = ST_TOO_LONG;
					end else if (store_full) begin
						rsp_d.status = ST_FULL;
					end else begin
						// Push the fresh node onto the target slot.
						head_we_x    = 1'b1;
						head_waddr_x = slot_s1;
						head_wdata_x = free_head_q[NW-1:0];
						node_we      = 1'b1;
						node_waddr   = free_head_q[NW-1:0];
						node_wdata   = {LW'(head_rdata), pay_wdata};
						free_head_d  = (ins_link != '0) ? ins_link : free_head_q + 1'b1;
						hwm_d        = ins_fresh ? hwm_q + 1'b1 : hwm_q;
						if (slot_s1 == pos_q) begin
							cur_head_d = free_head_q[NW-1:0];
						end
						rsp_d.status = ST_INSERTED;
					end
				end
				REQ_ADVANCE: begin
					pos_d        = pos_inc;
					cur_head_d   = head_rdata;
					rsp_d.status = ST_ADVANCED;
				end
				default: begin
					if (cur_head_q == '0) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						// Unlink the head and return it to the free list; keep its payload.
						head_we_x         = 1'b1;
						head_waddr_x      = pos_q;
						head_wdata_x      = NW'(next_rdata);
						node_we           = 1'b1;
						node_waddr        = cur_head_q;
						node_wdata        = {free_head_q, pay_rdata};
						free_head_d       = LW'(cur_head_q);
						cur_head_d        = NW'(next_rdata);
						rsp_d.status      = ST_POPPED;
						rsp_d.out_address = 32'(pay_rdata[LEN_WIDTH +: ADDR_WIDTH]);
						rsp_d.out_length  = 16'(pay_rdata[LEN_WIDTH-1:0]);
					end
				end
			endcase
		end
		rsp_d.slot_drained = (cur_head_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			pos_q       <= '0;
			cur_head_q  <= '0;
			free_head_q <= LW'(1);
			hwm_q       <= LW'(1);
			req_s1      <= '0;
			slot_s1     <= '0;
			too_long_s1 <= 1'b0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == PW'(SLOTS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_s1      <= req;
						slot_s1     <= slot_acc;
						too_long_s1 <= too_long_acc;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					pos_q       <= pos_d;
					cur_head_q  <= cur_head_d;
					free_head_q <= free_head_d;
					hwm_q       <= hwm_d;
					result_q    <= rsp_d;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/twdq_ram.sv =====
module twdq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/twdq_checker.sv =====
`include "timing_wheel_delay_queue_macros.svh"

module twdq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input twdq_pkg::twdq_req_t req,
	input logic                done,
	input twdq_pkg::twdq_rsp_t result
);

	import twdq_pkg::*;

	logic xfer;
	logic nonpop_seen;
	logic empty_seen;
	logic pay_zero;
	logic drained;

	assign xfer        = start && !busy;
	assign nonpop_seen = done && (result.status != ST_POPPED);
	assign empty_seen  = done && (result.status == ST_EMPTY);
	assign pay_zero    = (result.out_address == '0) && (result.out_length == '0);
	assign drained     = result.slot_drained;

	`TWDQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, xfer, busy, "not busy after transfer")
	`TWDQ_ASSERT_IMPL(a_done_follows, clk, arst_n, done, $past(xfer, 2), "orphan result")
	`TWDQ_ASSERT_NEXT(a_single_strobe, clk, arst_n, done, !done, "done held over")
	`TWDQ_ASSERT_IMPL(a_payload_clear, clk, arst_n, nonpop_seen, pay_zero, "stale payload")
	`TWDQ_ASSERT_IMPL(a_empty_drained, clk, arst_n, empty_seen, drained, "entries on empty pop")

endmodule

bind timing_wheel_delay_queue twdq_checker u_twdq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);
